### rtl/pqae_pkg.sv
`timescale 1ns / 1ps

package pqae_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  // at most this many evictions per reject command
  localparam int RESULT_LIMIT    = 16;
  localparam int NW              = $clog2(RESULT_LIMIT + 1);

  localparam int ID_W   = 8;
  localparam int PRI_W  = 4;
  localparam int WAIT_W = 16;
  localparam int CIDX_W = 2;

  localparam logic [WAIT_W-1:0] WAIT_MAX     = '1;
  localparam logic [WAIT_W-1:0] MAX_WAIT_RST = 16'd4;
  localparam logic [PRI_W-1:0]  PRIO_CAP_RST = 4'd15;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_MAX_WAIT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_PRIO_CAP = 2'd1;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_NO_EVCT = 2'd3;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_AGE    = 2'd2,
    OP_REJECT = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } ctrl_state_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_PUSH,
    DP_POP,
    DP_AGE,
    DP_SCAN_INIT,
    DP_ROTATE,
    DP_EVICT,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic out_free;      // output register can load this cycle
    logic scan_done;     // every entry of the scan has been visited
    logic head_overdue;  // head entry is to be evicted
    logic pend_valid;    // an evicted entry waits for its last flag
  } dp_status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic [WAIT_W-1:0] wait_cnt;
  } entry_t;

endpackage

### rtl/pqae_ctrl.sv
`timescale 1ns / 1ps

module pqae_ctrl
  import pqae_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic [1:0] op,
  input  dp_status_t st,
  output logic       cmd_stall,
  output dp_op_t     dp_op
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_op      = DP_NOP;
    cmd_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        cmd_stall = !st.out_free;
        if (cmd_valid && st.out_free) begin
          unique case (op_t'(op))
            OP_PUSH:   dp_op = DP_PUSH;
            OP_POP:    dp_op = DP_POP;
            OP_AGE:    dp_op = DP_AGE;
            OP_REJECT: begin
              dp_op      = DP_SCAN_INIT;
              state_next = ST_SCAN;
            end
            default:   dp_op = DP_NOP;
          endcase
        end
      end
      ST_SCAN: begin
        if (st.scan_done) begin
          if (st.out_free) begin
            dp_op      = DP_FINISH;
            state_next = ST_IDLE;
          end
        end else if (st.head_overdue) begin
          // first eviction parks in the pending register; later ones push it out
          if (!st.pend_valid || st.out_free) begin
            dp_op = DP_EVICT;
          end
        end else begin
          dp_op = DP_ROTATE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### rtl/pqae_dp.sv
`timescale 1ns / 1ps

module pqae_dp
  import pqae_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_op_t            dp_op,
  input  logic [ID_W-1:0]   new_id,
  input  logic [PRI_W-1:0]  new_priority,
  input  logic [WAIT_W-1:0] max_wait,
  input  logic [PRI_W-1:0]  priority_cap,
  input  logic              res_stall,
  output dp_status_t        st,
  output logic              res_valid,
  output logic [1:0]        status,
  output logic [ID_W-1:0]   out_id,
  output logic [PRI_W-1:0]  out_priority,
  output logic [WAIT_W-1:0] out_wait,
  output logic              last
);

  localparam int CW = $clog2(DEPTH + 1);

  entry_t            slot      [DEPTH];
  entry_t            slot_next [DEPTH];
  logic [DEPTH-1:0]  below;
  logic [CW-1:0]     count;
  logic [CW-1:0]     steps;
  logic [NW-1:0]     n_evict;
  logic              pend_valid;
  entry_t            pend;
  entry_t            new_entry;
  logic              full;
  logic              out_free;

  assign full      = (count == CW'(DEPTH));
  assign out_free  = !res_valid || !res_stall;
  assign new_entry = '{id: new_id, pri: new_priority, wait_cnt: '0};

  assign st.out_free     = out_free;
  assign st.scan_done    = (steps == '0);
  assign st.head_overdue = (count != '0) && (slot[0].wait_cnt > max_wait) &&
                           (n_evict != NW'(RESULT_LIMIT));
  assign st.pend_valid   = pend_valid;

  // One cell per slot: shift up (pop, evict, rotate), shift down behind the
  // insertion point (push), or age in place.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t from_up;
    entry_t from_dn;
    entry_t aged;
    logic   below_prev;
    logic   is_tail;

    if (g < DEPTH - 1) begin : g_up
      assign from_up = slot[g+1];
    end else begin : g_up_end
      assign from_up = slot[g];
    end

    if (g > 0) begin : g_dn
      assign from_dn    = slot[g-1];
      assign below_prev = below[g-1];
    end else begin : g_dn_head
      assign from_dn    = slot[g];
      assign below_prev = 1'b0;
    end

    // queue stays sorted, so below is a run of ones from the insertion point
    assign below[g] = !((CW'(g) < count) && (slot[g].pri >= new_priority));
    assign is_tail  = (CW'(g) == count - CW'(1));

    always_comb begin
      aged.id       = slot[g].id;
      aged.wait_cnt = (slot[g].wait_cnt == WAIT_MAX) ? slot[g].wait_cnt :
                      slot[g].wait_cnt + WAIT_W'(1);
      aged.pri      = (slot[g].pri < priority_cap) ? slot[g].pri + PRI_W'(1) :
                      slot[g].pri;
    end

    always_comb begin
      slot_next[g] = slot[g];
      case (dp_op)
        DP_PUSH: begin
          if (!full) begin
            if (below[g] && !below_prev) begin
              slot_next[g] = new_entry;
            end else if (below[g]) begin
              slot_next[g] = from_dn;
            end
          end
        end
        DP_POP:    slot_next[g] = from_up;
        DP_AGE:    slot_next[g] = aged;
        DP_ROTATE: slot_next[g] = is_tail ? slot[0] : from_up;
        DP_EVICT:  slot_next[g] = from_up;
        default:   slot_next[g] = slot[g];
      endcase
    end

    always_ff @(posedge clk) begin
      slot[g] <= slot_next[g];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      steps      <= '0;
      n_evict    <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (dp_op)
        DP_PUSH: begin
          res_valid <= 1'b1;
          if (!full) begin
            count <= count + CW'(1);
          end
        end
        DP_POP: begin
          res_valid <= 1'b1;
          if (count != '0) begin
            count <= count - CW'(1);
          end
        end
        DP_AGE: res_valid <= 1'b1;
        DP_SCAN_INIT: begin
          steps   <= count;
          n_evict <= '0;
        end
        DP_ROTATE: steps <= steps - CW'(1);
        DP_EVICT: begin
          steps      <= steps - CW'(1);
          count      <= count - CW'(1);
          n_evict    <= n_evict + NW'(1);
          pend_valid <= 1'b1;
          if (pend_valid) begin
            res_valid <= 1'b1;
          end
        end
        DP_FINISH: begin
          res_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (dp_op)
      DP_PUSH: begin
        status       <= full ? STAT_FULL : STAT_OK;
        out_id       <= '0;
        out_priority <= '0;
        out_wait     <= '0;
        last         <= 1'b1;
      end
      DP_POP: begin
        if (count == '0) begin
          status       <= STAT_EMPTY;
          out_id       <= '0;
          out_priority <= '0;
          out_wait     <= '0;
        end else begin
          status       <= STAT_OK;
          out_id       <= slot[0].id;
          out_priority <= slot[0].pri;
          out_wait     <= slot[0].wait_cnt;
        end
        last <= 1'b1;
      end
      DP_AGE: begin
        status       <= STAT_OK;
        out_id       <= '0;
        out_priority <= '0;
        out_wait     <= '0;
        last         <= 1'b1;
      end
      DP_EVICT: begin
        pend <= slot[0];
        if (pend_valid) begin
          status       <= STAT_OK;
          out_id       <= pend.id;
          out_priority <= pend.pri;
          out_wait     <= pend.wait_cnt;
          last         <= 1'b0;
        end
      end
      DP_FINISH: begin
        if (pend_valid) begin
          status       <= STAT_OK;
          out_id       <= pend.id;
          out_priority <= pend.pri;
          out_wait     <= pend.wait_cnt;
        end else begin
          status       <= STAT_NO_EVCT;
          out_id       <= '0;
          out_priority <= '0;
          out_wait     <= '0;
        end
        last <= 1'b1;
      end
      default: ;
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond queue depth");

  a_steps_in_queue: assert property (@(posedge clk) disable iff (rst)
    steps <= count)
    else $error("scan steps exceed queued entries");

  a_evict_room: assert property (@(posedge clk) disable iff (rst)
    (dp_op == DP_EVICT) && pend_valid |-> out_free)
    else $error("eviction would overwrite an untaken result");

  // a reject scan rotates the row, so order is only checked outside a scan
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (steps == '0) && (count > CW'(1)) |-> (slot[0].pri >= slot[1].pri))
    else $error("queue head out of priority order");

endmodule

### rtl/priority_queue_aging_evict_top.sv
`timescale 1ns / 1ps

// Channel  Signals                               Transfer when
// -------  ------------------------------------  ---------------------------
// command  cmd_valid cmd_stall op new_id          cmd_valid && !cmd_stall
//          new_priority
// result   res_valid res_stall status out_id      res_valid && !res_stall
//          out_priority out_wait last
// config   cfg_valid cfg_ready cfg_index cfg_data cfg_valid && cfg_ready
//
// Push, pop and age complete in the cycle of their transfer; the result sits
// in the output register from the next cycle on.
// Reject visits the queue through its head, one entry per cycle unless a result
// stall holds an eviction: an overdue head is evicted (up to RESULT_LIMIT per
// reject), any other head rotates to the tail.
// Reset clears the entry count and loads max_wait = 4, priority_cap = 15;
// slot contents are not cleared.
// cmd_stall is high during a reject scan and while an untaken result is
// stalled in the output register.
module priority_queue_aging_evict_top
  import pqae_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // command channel
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic [1:0]        op,
  input  logic [ID_W-1:0]   new_id,
  input  logic [PRI_W-1:0]  new_priority,
  // result channel
  output logic              res_valid,
  input  logic              res_stall,
  output logic [1:0]        status,
  output logic [ID_W-1:0]   out_id,
  output logic [PRI_W-1:0]  out_priority,
  output logic [WAIT_W-1:0] out_wait,
  output logic              last,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [WAIT_W-1:0] cfg_data
);

  logic [WAIT_W-1:0] max_wait;
  logic [PRI_W-1:0]  priority_cap;
  dp_status_t        st;
  dp_op_t            dp_op;

  // registers are always writable; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_wait     <= MAX_WAIT_RST;
      priority_cap <= PRIO_CAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_WAIT: max_wait     <= cfg_data;
        CFG_PRIO_CAP: priority_cap <= cfg_data[PRI_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: picks one datapath step per cycle
  pqae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .op        (op),
    .st        (st),
    .cmd_stall (cmd_stall),
    .dp_op     (dp_op)
  );

  // sorted slot row, pending eviction and output register
  pqae_dp #(
    .DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .dp_op        (dp_op),
    .new_id       (new_id),
    .new_priority (new_priority),
    .max_wait     (max_wait),
    .priority_cap (priority_cap),
    .res_stall    (res_stall),
    .st           (st),
    .res_valid    (res_valid),
    .status       (status),
    .out_id       (out_id),
    .out_priority (out_priority),
    .out_wait     (out_wait),
    .last         (last)
  );

endmodule

### test/tb_priority_queue_aging_evict_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the aging priority queue.
// Commands go in from a pending queue, a shadow ready list predicts every result,
// and the monitor compares each result transfer against the oldest prediction.
module tb_priority_queue_aging_evict_top;
  import pqae_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer of any kind
  localparam int SETTLE_CYCLES  = 40;    // covers a full reject scan plus slack
  localparam int LONG_HOLD      = 120;   // receiver back-pressure stretch

  typedef struct {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } cmd_item_t;

  typedef struct {
    logic [1:0]        status;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic [WAIT_W-1:0] wait_cnt;
    logic              last;
  } result_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cmd_valid    = 1'b0;
  logic              cmd_stall;
  logic [1:0]        op           = '0;
  logic [ID_W-1:0]   new_id       = '0;
  logic [PRI_W-1:0]  new_priority = '0;
  logic              res_valid;
  logic              res_stall    = 1'b0;
  logic [1:0]        status;
  logic [ID_W-1:0]   out_id;
  logic [PRI_W-1:0]  out_priority;
  logic [WAIT_W-1:0] out_wait;
  logic              last;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index    = '0;
  logic [WAIT_W-1:0] cfg_data     = '0;

  // commands waiting to be driven, and results still owed by the block
  cmd_item_t cmd_q[$];
  result_t   pending_results[$];

  // shadow copy of the queue contents and of the two registers
  entry_t            ready_list[$];
  logic [WAIT_W-1:0] cur_max_wait = MAX_WAIT_RST;
  logic [PRI_W-1:0]  cur_cap      = PRIO_CAP_RST;

  int   errors       = 0;
  int   idle_pct     = 0;     // chance (percent) of starting an idle burst
  bit   cmd_busy     = 1'b0;  // a command is on the bus and not yet transferred
  int   gap_left     = 0;
  int   stall_left   = 0;
  int   hold_left    = 0;
  bit   hold_req     = 1'b0;
  int   quiet_cycles = 0;

  priority_queue_aging_evict_top dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .op           (op),
    .new_id       (new_id),
    .new_priority (new_priority),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .status       (status),
    .out_id       (out_id),
    .out_priority (out_priority),
    .out_wait     (out_wait),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow queue: applies one command and queues the results it must produce.
  // ---------------------------------------------------------------------------
  function automatic void apply_command(cmd_item_t c);
    result_t r;
    entry_t  e;
    int      pos;
    int      n;
    int      i;
    r.status   = STAT_OK;
    r.id       = '0;
    r.pri      = '0;
    r.wait_cnt = '0;
    r.last     = 1'b1;
    case (c.op)
      OP_PUSH: begin
        if (ready_list.size() >= QUEUE_DEPTH_DEF) begin
          r.status = STAT_FULL;
        end else begin
          // new entry goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < ready_list.size() && ready_list[pos].pri >= c.pri) pos++;
          e.id       = c.id;
          e.pri      = c.pri;
          e.wait_cnt = '0;
          ready_list.insert(pos, e);
        end
        pending_results.push_back(r);
      end
      OP_POP: begin
        if (ready_list.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.id       = ready_list[0].id;
          r.pri      = ready_list[0].pri;
          r.wait_cnt = ready_list[0].wait_cnt;
          ready_list.delete(0);
        end
        pending_results.push_back(r);
      end
      OP_AGE: begin
        // wait saturates; priority climbs only while below the cap
        for (i = 0; i < ready_list.size(); i++) begin
          e = ready_list[i];
          if (e.wait_cnt != WAIT_MAX) e.wait_cnt++;
          if (e.pri < cur_cap) e.pri++;
          ready_list[i] = e;
        end
        pending_results.push_back(r);
      end
      default: begin
        // reject: evict overdue entries in queue order, capped per command
        n = 0;
        i = 0;
        while (i < ready_list.size() && n < RESULT_LIMIT) begin
          if (ready_list[i].wait_cnt > cur_max_wait) begin
            r.id       = ready_list[i].id;
            r.pri      = ready_list[i].pri;
            r.wait_cnt = ready_list[i].wait_cnt;
            r.last     = 1'b0;
            pending_results.push_back(r);
            ready_list.delete(i);
            n++;
          end else begin
            i++;
          end
        end
        if (n == 0) begin
          r.status = STAT_NO_EVCT;
          pending_results.push_back(r);
        end else begin
          pending_results[pending_results.size() - 1].last = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic void add_cmd(op_t o, int id, int pri);
    cmd_item_t c;
    c.op  = o;
    c.id  = id[ID_W-1:0];
    c.pri = pri[PRI_W-1:0];
    cmd_q.push_back(c);
  endfunction

  // random mix; id and priority are randomized on every op, even where ignored
  function automatic void add_random(int n, int push_pct, int pop_pct, int age_pct);
    int r;
    op_t o;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) o = OP_PUSH;
      else if (r < push_pct + pop_pct) o = OP_POP;
      else if (r < push_pct + pop_pct + age_pct) o = OP_AGE;
      else o = OP_REJECT;
      add_cmd(o, $urandom_range(0, 255), $urandom_range(0, 15));
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: changes on the falling edge, holds a payload until transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && cmd_valid && !cmd_stall) begin
      apply_command(cmd_q.pop_front());
      cmd_busy = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!cmd_busy) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (cmd_q.size() > 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        gap_left = $urandom_range(0, 9);  // start an idle burst, counted down in gap_left
        cmd_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        op           <= cmd_q[0].op;
        new_id       <= cmd_q[0].id;
        new_priority <= cmd_q[0].pri;
        cmd_valid    <= 1'b1;
        cmd_busy = 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: stall bursts, plus one long hold so the block backs up.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD - 1;
      res_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 9);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual status %0d id %0d",
                 $time, status, out_id);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status);
        check_field("out_id", want.id, out_id);
        check_field("out_priority", want.pri, out_priority);
        check_field("out_wait", want.wait_cnt, out_wait);
        check_field("last", want.last, last);
      end
    end
  end

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes and phase control
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [WAIT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MAX_WAIT) cur_max_wait = val;
    else if (idx == CFG_PRIO_CAP) cur_cap = val[PRI_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block is idle once every command went out and every result came back
  task automatic wait_idle();
    while (cmd_q.size() != 0 || cmd_busy || pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int k;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-queue cases, FIFO among equal priorities,
    // entries at and above the cap left alone by aging, multi-entry eviction.
    write_reg(CFG_MAX_WAIT, 16'd2);
    write_reg(CFG_PRIO_CAP, 16'd7);
    idle_pct = 20;
    add_cmd(OP_POP, 0, 0);
    add_cmd(OP_REJECT, 0, 0);
    add_cmd(OP_AGE, 0, 0);
    add_cmd(OP_PUSH, 8'h00, 0);
    add_cmd(OP_PUSH, 8'hFF, 15);
    add_cmd(OP_PUSH, 8'hAA, 15);
    add_cmd(OP_PUSH, 8'h55, 7);
    add_cmd(OP_PUSH, 8'h56, 7);
    repeat (3) add_cmd(OP_AGE, 0, 0);
    add_cmd(OP_REJECT, 0, 0);  // every entry is overdue now
    wait_idle();

    // Fill to capacity, one refused push, then evict the maximum in one reject.
    write_reg(CFG_MAX_WAIT, 16'd0);
    write_reg(CFG_PRIO_CAP, 16'd0);
    for (k = 0; k < QUEUE_DEPTH_DEF; k++) add_cmd(OP_PUSH, 8'h10 + k, $urandom_range(0, 15));
    add_cmd(OP_PUSH, 8'hEE, 3);
    add_cmd(OP_AGE, 0, 0);
    add_cmd(OP_REJECT, 0, 0);
    wait_idle();

    // Random phases; the second one backs the result side up for a long stretch,
    // the last two run without idling.
    for (k = 0; k < 5; k++) begin
      write_reg(CFG_MAX_WAIT, WAIT_W'($urandom_range(0, 6)));
      write_reg(CFG_PRIO_CAP, WAIT_W'($urandom_range(0, 15)));
      case (k)
        0: idle_pct = 30;
        1: idle_pct = 15;
        2: idle_pct = 40;
        default: idle_pct = 0;
      endcase
      if (k == 1) begin
        hold_req = 1'b1;
        add_random(18, 60, 10, 25);
      end else begin
        add_random(18, 40, 20, 25);
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pqae_pkg.sv
rtl/pqae_ctrl.sv
rtl/pqae_dp.sv
rtl/priority_queue_aging_evict_top.sv
test/tb_priority_queue_aging_evict_top.sv
